// File: design/frp_pkg.sv
// Shared types and constants for the flash erase range planner.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package frp_pkg;

	// Field widths of the request and command channels
	localparam int START_W = 24;
	localparam int COUNT_W = 19;
	localparam int CODE_W  = 8;
	localparam int ADDR_W  = 24;

	// Default parameter values
	localparam int DEF_ADDR_BITS         = 24;
	localparam int DEF_MAX_REQUEST_BYTES = 262144;

	// Erase geometry, in 4KB sectors
	localparam int SECTOR_SHIFT      = 12;
	localparam int SECTORS_PER_BLOCK = 16;
	localparam int SECTORS_PER_HALF  = 8;

	// Command limit per request
	localparam int MAX_RESULTS = 20;
	localparam int NUM_W       = $clog2(MAX_RESULTS);

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SECTOR_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_CODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_CODE  = 2'd2;

	// Reset values of the command bytes
	localparam logic [CODE_W-1:0] RST_SECTOR_CODE = 8'h20;
	localparam logic [CODE_W-1:0] RST_HALF_CODE   = 8'h52;
	localparam logic [CODE_W-1:0] RST_BLOCK_CODE  = 8'hD8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_EMPTY
	} seq_state_t;

	typedef enum logic [1:0] {
		ERASE_SECTOR,
		ERASE_HALF,
		ERASE_BLOCK
	} erase_kind_t;

	// Command bytes from the configuration registers
	typedef struct packed {
		logic [CODE_W-1:0] sector_code;
		logic [CODE_W-1:0] half_code;
		logic [CODE_W-1:0] block_code;
	} cfg_codes_t;

	// Verdict of the step unit for the current sector
	typedef struct packed {
		erase_kind_t kind;
		logic        done;
	} step_res_t;

endpackage

// File: design/frp_channels.sv
// Valid/ready channel interfaces for erase requests and erase commands.
// Depends on frp_pkg for the field widths.
`timescale 1ns / 1ps

interface erase_req_if;
	logic                        valid;
	logic                        ready;
	logic [frp_pkg::START_W-1:0] start_address;
	logic [frp_pkg::COUNT_W-1:0] byte_count;

	modport source (output valid, start_address, byte_count, input ready);
	modport sink   (input valid, start_address, byte_count, output ready);
endinterface

interface erase_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [frp_pkg::CODE_W-1:0] erase_command;
	logic [frp_pkg::ADDR_W-1:0] erase_address;
	logic                       command_valid;
	logic                       last_command;

	modport source (output valid, erase_command, erase_address, command_valid,
		last_command, input ready);
	modport sink   (input valid, erase_command, erase_address, command_valid,
		last_command, output ready);
endinterface

// File: design/flash_erase_range_planner_top.sv
// Top level of the flash erase range planner: command byte registers and
// the request sequencer. Depends on frp_pkg, frp_channels, frp_sequencer.
//
// Usage:
//   req  - erase request channel (start_address, byte_count), valid/ready.
//   cmd  - erase command channel (erase_command, erase_address,
//          command_valid, last_command), valid/ready; one transfer per command.
//   cfg  - write-only port (cfg_we, cfg_index, cfg_wdata) for the sector,
//          half-block and block erase command bytes; write it while idle.
// A request of N commands is accepted at one edge, then one command is
// loaded into the output register per cycle while the receiver does not stall;
// with default parameters N is at most 20. The rate is set by the single
// step unit, which evaluates one sector position per cycle. A zero byte
// count gives one result with command_valid low and last_command high.
// The next request is taken once the last command is in the output register.
// When the receiver stalls the output register holds and the sequencer waits.
// Reset clears the sequencer to idle, empties the output register and loads
// the command bytes 0x20, 0x52 and 0xD8.
`timescale 1ns / 1ps

module flash_erase_range_planner_top #(
	parameter int ADDR_BITS         = frp_pkg::DEF_ADDR_BITS,
	parameter int MAX_REQUEST_BYTES = frp_pkg::DEF_MAX_REQUEST_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	erase_req_if.sink                     req,
	erase_cmd_if.source                   cmd,
	input  logic                          cfg_we,
	input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [frp_pkg::CODE_W-1:0]    cfg_wdata
);

	frp_pkg::cfg_codes_t codes_q;

	// Command byte registers; writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.sector_code <= frp_pkg::RST_SECTOR_CODE;
			codes_q.half_code   <= frp_pkg::RST_HALF_CODE;
			codes_q.block_code  <= frp_pkg::RST_BLOCK_CODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				frp_pkg::REG_SECTOR_CODE: codes_q.sector_code <= cfg_wdata;
				frp_pkg::REG_HALF_CODE:   codes_q.half_code   <= cfg_wdata;
				frp_pkg::REG_BLOCK_CODE:  codes_q.block_code  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	frp_sequencer #(
		.ADDR_BITS         (ADDR_BITS),
		.MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.codes  (codes_q),
		.req    (req),
		.cmd    (cmd)
	);

endmodule

// File: design/frp_step_unit.sv
// Shared step unit: one subtract and a few compares per sector decide the
// erase size, the next cursor and whether the range is finished. Uses frp_pkg.
`timescale 1ns / 1ps

module frp_step_unit #(
	parameter int SEC_W = 12
) (
	input  logic [SEC_W-1:0]  cursor,
	input  logic [SEC_W-1:0]  end_sector,
	output logic [SEC_W-1:0]  next_cursor,
	output frp_pkg::step_res_t res
);

	localparam logic [SEC_W-1:0] BLOCK_SPAN = SEC_W'(frp_pkg::SECTORS_PER_BLOCK - 1);
	localparam logic [SEC_W-1:0] HALF_SPAN  = SEC_W'(frp_pkg::SECTORS_PER_HALF - 1);
	localparam logic [SEC_W-1:0] BLOCK_STEP = SEC_W'(frp_pkg::SECTORS_PER_BLOCK);
	localparam logic [SEC_W-1:0] HALF_STEP  = SEC_W'(frp_pkg::SECTORS_PER_HALF);

	frp_pkg::erase_kind_t kind;
	logic [SEC_W-1:0]     remain;
	logic [SEC_W-1:0]     step;

	// Sectors left after the cursor; the cursor never passes the end sector
	assign remain = end_sector - cursor;

	// Pick the largest aligned unit that fits
	always_comb begin
		if (cursor[3:0] == 4'd0 && remain >= BLOCK_SPAN) begin
			kind = frp_pkg::ERASE_BLOCK;
			step = BLOCK_STEP;
		end else if (cursor[2:0] == 3'd0 && remain >= HALF_SPAN) begin
			kind = frp_pkg::ERASE_HALF;
			step = HALF_STEP;
		end else begin
			kind = frp_pkg::ERASE_SECTOR;
			step = SEC_W'(1);
		end
	end

	// Advance the cursor; finished once the unit reaches past the end sector
	assign next_cursor = cursor + step;
	assign res         = '{kind: kind, done: (remain < step)};

endmodule

// File: design/frp_sequencer.sv
// Request sequencer: takes an erase request, sets up the sector range and
// drives the step unit once per command into an output register.
// Depends on frp_pkg, frp_channels and frp_step_unit.
`timescale 1ns / 1ps

module frp_sequencer #(
	parameter int ADDR_BITS         = frp_pkg::DEF_ADDR_BITS,
	parameter int MAX_REQUEST_BYTES = frp_pkg::DEF_MAX_REQUEST_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  frp_pkg::cfg_codes_t codes,
	erase_req_if.sink           req,
	erase_cmd_if.source         cmd
);

	localparam int SEC_W = ADDR_BITS - frp_pkg::SECTOR_SHIFT;
	localparam int AW    = (ADDR_BITS > frp_pkg::ADDR_W) ? ADDR_BITS : frp_pkg::ADDR_W;
	localparam int WB    = AW + 1;
	localparam logic [WB-1:0] TOP = WB'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [WB-1:0] MAX_BYTES = WB'(MAX_REQUEST_BYTES);
	localparam logic [frp_pkg::NUM_W-1:0] LAST_NUM =
		frp_pkg::NUM_W'(frp_pkg::MAX_RESULTS - 1);

	frp_pkg::seq_state_t state_q, state_next;

	logic [SEC_W-1:0]          cursor_q;
	logic [SEC_W-1:0]          end_q;
	logic [frp_pkg::NUM_W-1:0] num_q;

	logic                       out_valid_q;
	logic [frp_pkg::CODE_W-1:0] out_code_q;
	logic [frp_pkg::ADDR_W-1:0] out_addr_q;
	logic                       out_cmd_valid_q;
	logic                       out_last_q;

	logic [WB-1:0]    count_ext;
	logic [WB-1:0]    count_sat;
	logic [WB-1:0]    start_ext;
	logic [WB-1:0]    start_clamp;
	logic [WB-1:0]    last_byte;
	logic [WB-1:0]    last_clamp;
	logic             count_zero;
	logic             accept;
	logic             slot_free;
	logic             load_emit;
	logic             load_empty;
	logic             final_cmd;
	logic [SEC_W-1:0] next_cursor;
	logic [AW-1:0]    addr_full;
	logic [frp_pkg::CODE_W-1:0] sel_code;
	frp_pkg::step_res_t step_res;

	// Range setup: saturate the count, clamp to the device end
	assign count_ext   = WB'(req.byte_count);
	assign count_sat   = (count_ext > MAX_BYTES) ? MAX_BYTES : count_ext;
	assign start_ext   = WB'(req.start_address);
	assign start_clamp = (start_ext > TOP) ? TOP : start_ext;
	assign last_byte   = start_clamp + count_sat - WB'(1);
	assign last_clamp  = (last_byte > TOP) ? TOP : last_byte;
	assign count_zero  = (req.byte_count == '0);

	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || cmd.ready;

	frp_step_unit #(
		.SEC_W (SEC_W)
	) u_step (
		.cursor      (cursor_q),
		.end_sector  (end_q),
		.next_cursor (next_cursor),
		.res         (step_res)
	);

	assign final_cmd = step_res.done || (num_q == LAST_NUM);

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			frp_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_next = count_zero ? frp_pkg::ST_EMPTY : frp_pkg::ST_EMIT;
				end
			end
			frp_pkg::ST_EMIT: begin
				if (slot_free && final_cmd) begin
					state_next = frp_pkg::ST_IDLE;
				end
			end
			frp_pkg::ST_EMPTY: begin
				if (slot_free) begin
					state_next = frp_pkg::ST_IDLE;
				end
			end
			default: state_next = frp_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		req.ready  = 1'b0;
		load_emit  = 1'b0;
		load_empty = 1'b0;
		unique case (state_q)
			frp_pkg::ST_IDLE:  req.ready  = 1'b1;
			frp_pkg::ST_EMIT:  load_emit  = slot_free;
			frp_pkg::ST_EMPTY: load_empty = slot_free;
			default: req.ready = 1'b0;
		endcase
	end

	// Command byte for the chosen erase size
	always_comb begin
		unique case (step_res.kind)
			frp_pkg::ERASE_BLOCK: sel_code = codes.block_code;
			frp_pkg::ERASE_HALF:  sel_code = codes.half_code;
			default:              sel_code = codes.sector_code;
		endcase
	end

	assign addr_full = AW'({cursor_q, {frp_pkg::SECTOR_SHIFT{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= frp_pkg::ST_IDLE;
			cursor_q    <= '0;
			end_q       <= '0;
			num_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			// Load the range on a request transfer
			if (accept) begin
				cursor_q <= start_clamp[ADDR_BITS-1:frp_pkg::SECTOR_SHIFT];
				end_q    <= last_clamp[ADDR_BITS-1:frp_pkg::SECTOR_SHIFT];
				num_q    <= '0;
			end else if (load_emit) begin
				cursor_q <= next_cursor;
				num_q    <= num_q + frp_pkg::NUM_W'(1);
			end
			// Hold the result until the command transfer
			if (load_emit || load_empty) begin
				out_valid_q <= 1'b1;
			end else if (cmd.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load_emit) begin
			out_code_q      <= sel_code;
			out_addr_q      <= addr_full[frp_pkg::ADDR_W-1:0];
			out_cmd_valid_q <= 1'b1;
			out_last_q      <= final_cmd;
		end else if (load_empty) begin
			out_code_q      <= '0;
			out_addr_q      <= '0;
			out_cmd_valid_q <= 1'b0;
			out_last_q      <= 1'b1;
		end
	end

	assign cmd.valid         = out_valid_q;
	assign cmd.erase_command = out_code_q;
	assign cmd.erase_address = out_addr_q;
	assign cmd.command_valid = out_cmd_valid_q;
	assign cmd.last_command  = out_last_q;

`ifndef ASSERT_OFF
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == frp_pkg::ST_EMIT |-> cursor_q <= end_q)
		else $error("erase cursor passed the end sector");

	a_num_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == frp_pkg::ST_EMIT |-> num_q <= LAST_NUM)
		else $error("command count beyond limit");

	a_final_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		load_emit && final_cmd |=> state_q == frp_pkg::ST_IDLE && out_valid_q && out_last_q)
		else $error("final command not marked last");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_cmd_valid_q |-> out_last_q && out_addr_q == '0 && out_code_q == '0)
		else $error("empty result carries a command");
`endif

endmodule

// File: sim/flash_erase_range_planner_top_tb.sv
// Testbench for flash_erase_range_planner_top: drives erase requests and
// command byte writes, predicts every erase command and checks each transfer.
// Depends on frp_pkg, frp_channels and the design files under design/.
`timescale 1ns / 1ps

module flash_erase_range_planner_top_tb;

	localparam int          IDLE_PCT      = 19;
	localparam int          SETTLE_CYCLES = 25;
	localparam int          STALL_LIMIT   = 4000;
	localparam int          PHASE_ITEMS   = 50;
	localparam int          NUM_PHASES    = 6;
	localparam logic [31:0] DEVICE_TOP    = (32'd1 << frp_pkg::DEF_ADDR_BITS) - 32'd1;
	localparam logic [31:0] REQUEST_CAP   = 32'(frp_pkg::DEF_MAX_REQUEST_BYTES);

	// Unused register index; writes to it must leave every code alone
	localparam logic [frp_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [frp_pkg::CODE_W-1:0] erase_command;
		logic [frp_pkg::ADDR_W-1:0] erase_address;
		logic                       command_valid;
		logic                       last_command;
	} erase_cmd_t;

	// Plans the commands of each accepted request and checks transfers in order
	class erase_plan_checker;
		erase_cmd_t                 planned_cmds[$];
		logic [frp_pkg::CODE_W-1:0] sector_code;
		logic [frp_pkg::CODE_W-1:0] half_code;
		logic [frp_pkg::CODE_W-1:0] block_code;
		int                         errors;

		function new();
			sector_code = frp_pkg::RST_SECTOR_CODE;
			half_code   = frp_pkg::RST_HALF_CODE;
			block_code  = frp_pkg::RST_BLOCK_CODE;
			errors      = 0;
		endfunction

		function void set_code(logic [frp_pkg::CFG_IDX_W-1:0] idx,
				logic [frp_pkg::CODE_W-1:0] value);
			unique case (idx)
				frp_pkg::REG_SECTOR_CODE: sector_code = value;
				frp_pkg::REG_HALF_CODE:   half_code   = value;
				frp_pkg::REG_BLOCK_CODE:  block_code  = value;
				default: ;
			endcase
		endfunction

		// Greedy cover: block if aligned and inside, else half-block, else sector
		function void plan_request(logic [frp_pkg::START_W-1:0] start,
				logic [frp_pkg::COUNT_W-1:0] count);
			logic [31:0] bytes;
			logic [31:0] last_byte;
			logic [31:0] cursor;
			logic [31:0] stop;
			logic [31:0] stride;
			erase_cmd_t  c;
			bytes = (count > REQUEST_CAP) ? REQUEST_CAP : 32'(count);
			if (bytes == 0) begin
				c = '{erase_command: '0, erase_address: '0, command_valid: 1'b0,
					last_command: 1'b1};
				planned_cmds.push_back(c);
				return;
			end
			last_byte = 32'(start) + bytes - 32'd1;
			if (last_byte > DEVICE_TOP)
				last_byte = DEVICE_TOP;
			cursor = 32'(start) >> frp_pkg::SECTOR_SHIFT;
			stop   = last_byte >> frp_pkg::SECTOR_SHIFT;
			for (int n = 0; n < frp_pkg::MAX_RESULTS; n++) begin
				if (cursor % frp_pkg::SECTORS_PER_BLOCK == 0 &&
						cursor + frp_pkg::SECTORS_PER_BLOCK - 1 <= stop) begin
					c.erase_command = block_code;
					stride = frp_pkg::SECTORS_PER_BLOCK;
				end else if (cursor % frp_pkg::SECTORS_PER_HALF == 0 &&
						cursor + frp_pkg::SECTORS_PER_HALF - 1 <= stop) begin
					c.erase_command = half_code;
					stride = frp_pkg::SECTORS_PER_HALF;
				end else begin
					c.erase_command = sector_code;
					stride = 1;
				end
				c.erase_address = frp_pkg::ADDR_W'(cursor << frp_pkg::SECTOR_SHIFT);
				c.command_valid = 1'b1;
				cursor = cursor + stride;
				c.last_command = (cursor > stop) || (n == frp_pkg::MAX_RESULTS - 1);
				planned_cmds.push_back(c);
				if (c.last_command)
					break;
			end
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			errors++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
		endfunction

		function void check_command(erase_cmd_t got);
			erase_cmd_t want;
			if (planned_cmds.size() == 0) begin
				errors++;
				$display("%0t: expected no command, got cmd 0x%0h addr 0x%0h",
					$time, got.erase_command, got.erase_address);
				return;
			end
			want = planned_cmds.pop_front();
			if (got.erase_command !== want.erase_command)
				report("erase_command", 32'(want.erase_command), 32'(got.erase_command));
			if (got.erase_address !== want.erase_address)
				report("erase_address", 32'(want.erase_address), 32'(got.erase_address));
			if (got.command_valid !== want.command_valid)
				report("command_valid", 32'(want.command_valid), 32'(got.command_valid));
			if (got.last_command !== want.last_command)
				report("last_command", 32'(want.last_command), 32'(got.last_command));
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [frp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [frp_pkg::CODE_W-1:0]    cfg_wdata;
	bit                            gaps_on = 1'b1;
	int unsigned                   quiet_cycles = 0;
	erase_plan_checker             book = new();

	erase_req_if req_if ();
	erase_cmd_if cmd_if ();

	flash_erase_range_planner_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.cmd       (cmd_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: stall at random, change ready on the falling edge
	initial begin
		cmd_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			cmd_if.ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Check every command transfer
	always @(posedge clk) begin
		if (arst_n && cmd_if.valid && cmd_if.ready)
			book.check_command('{erase_command: cmd_if.erase_command,
				erase_address: cmd_if.erase_address, command_valid: cmd_if.command_valid,
				last_command: cmd_if.last_command});
	end

	// Watchdog: end the run if nothing transfers for too long
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (cmd_if.valid && cmd_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one request, idling first at random; hold valid once raised until the transfer
	task automatic send_request(input logic [frp_pkg::START_W-1:0] a,
			input logic [frp_pkg::COUNT_W-1:0] n);
		@(negedge clk);
		while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid         <= 1'b1;
		req_if.start_address <= a;
		req_if.byte_count    <= n;
		do @(posedge clk); while (!req_if.ready);
		book.plan_request(a, n);
	endtask

	// Random request, biased towards aligned starts, half-block multiple counts and the edges
	task automatic send_random_request();
		logic [frp_pkg::START_W-1:0] a;
		logic [frp_pkg::COUNT_W-1:0] n;
		case ($urandom_range(0, 9))
			0, 1:    a = {8'($urandom_range(0, 255)), 16'h0000};
			2:       a = {9'($urandom_range(0, 511)), 15'h0000};
			3, 4:    a = {12'($urandom_range(0, 4095)), 12'h000};
			5:       a = frp_pkg::START_W'(DEVICE_TOP - $urandom_range(0, 32'h4FFFF));
			default: a = frp_pkg::START_W'($urandom);
		endcase
		case ($urandom_range(0, 19))
			0, 1:          n = '0;
			2:             n = frp_pkg::COUNT_W'($urandom_range(REQUEST_CAP + 1, 32'h7FFFF));
			3:             n = frp_pkg::COUNT_W'(REQUEST_CAP);
			4, 5, 6, 7:    n = frp_pkg::COUNT_W'($urandom_range(1, 8) * 32'h8000);
			8, 9, 10, 11:  n = frp_pkg::COUNT_W'($urandom_range(1, 32'h3000));
			default:       n = frp_pkg::COUNT_W'($urandom_range(1, REQUEST_CAP));
		endcase
		send_request(a, n);
	endtask

	// Drop valid, wait for every planned command, then let the block settle
	task automatic drain();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (book.planned_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_code(input logic [frp_pkg::CFG_IDX_W-1:0] idx,
			input logic [frp_pkg::CODE_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		book.set_code(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_wdata            = '0;
		req_if.valid         = 1'b0;
		req_if.start_address = '0;
		req_if.byte_count    = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests with the reset command bytes
		send_request(24'h000000, 19'h00000);    // zero count
		send_request(24'hFFFFFF, 19'h00000);
		send_request(24'h000000, 19'h00001);    // single byte
		send_request(24'h000000, 19'h08000);    // one half-block
		send_request(24'h000000, 19'h10000);    // one block
		send_request(24'h008000, 19'h10000);    // two half-blocks
		send_request(24'h000FFF, 19'h00002);    // straddles two sectors
		send_request(24'h000000, 19'h40000);    // largest allowed count
		send_request(24'h001800, 19'h40000);    // misaligned, many commands
		send_request(24'h007000, 19'h0A000);
		send_request(24'h000123, 19'h7FFFF);    // oversized count saturates
		send_request(24'h000000, 19'h40001);
		send_request(24'hFFFFFF, 19'h40000);    // past device end, clamped
		send_request(24'hFF0000, 19'h7FFFF);
		send_request(24'hFC1234, 19'h40000);
		send_request(24'hFF8000, 19'h08000);
		send_request(24'hFFF000, 19'h01000);
		send_request(24'hABCDEF, 19'h12345);
		send_request(24'h5A5A5A, 19'h2A5A5);
		send_request(24'h0F0000, 19'h0FFFF);    // one byte short of a block
		drain();

		// Random phases, each under its own command bytes
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin
					write_code(frp_pkg::REG_SECTOR_CODE, 8'h00);
					write_code(frp_pkg::REG_HALF_CODE, 8'h00);
					write_code(frp_pkg::REG_BLOCK_CODE, 8'h00);
					write_code(REG_SPARE, 8'hFF);
				end
				1: begin
					write_code(frp_pkg::REG_SECTOR_CODE, 8'hFF);
					write_code(frp_pkg::REG_HALF_CODE, 8'hFF);
					write_code(frp_pkg::REG_BLOCK_CODE, 8'hFF);
					write_code(REG_SPARE, 8'h00);
				end
				default: begin
					write_code(frp_pkg::REG_SECTOR_CODE, 8'($urandom));
					write_code(frp_pkg::REG_HALF_CODE, 8'($urandom));
					write_code(frp_pkg::REG_BLOCK_CODE, 8'($urandom));
				end
			endcase
			// One phase runs back to back with no idling on either side
			gaps_on = (phase != 3);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random_request();
			drain();
		end

		if (book.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: flash_erase_range_planner_top.f
design/frp_pkg.sv
design/frp_channels.sv
design/frp_step_unit.sv
design/frp_sequencer.sv
design/flash_erase_range_planner_top.sv
sim/flash_erase_range_planner_top_tb.sv
